@@ rtl/rxrb_pkg.sv @@
// rxrb_pkg: shared constants, codes and types for the receive ring buffer
// no dependencies; compiled first
package rxrb_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int FILL_W     = 5;
    localparam int MINLEN_W   = 5;
    localparam int CMP_W      = (CNT_W > MINLEN_W) ? CNT_W : MINLEN_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_FLUSH   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_BYTE = 1'b0,
        CFG_MIN_LEN   = 1'b1
    } cfg_idx_t;

    // one write port and one read port on the ring store
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

@@ rtl/rxrb_intf.sv @@
// rxrb channel interfaces: request, result and configuration write channels
// depends on rxrb_pkg
interface rxrb_cmd_if
    import rxrb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_error;

    modport source (output valid, operation, rx_byte, rx_error, input ready);
    modport sink   (input valid, operation, rx_byte, rx_error, output ready);
endinterface

interface rxrb_rsp_if
    import rxrb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic [FILL_W-1:0] fill_count;
    logic              frame_ready;
    logic              underflow;

    modport source (output valid, read_data, fill_count, frame_ready, underflow,
                    input ready);
    modport sink   (input valid, read_data, fill_count, frame_ready, underflow,
                    output ready);
endinterface

interface rxrb_cfg_if
    import rxrb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rxrb_ram.sv @@
// rxrb_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rxrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rxrb_ctrl.sv @@
// rxrb_ctrl: pointers, fill count, notify flag, sequencer and result register
// depends on rxrb_pkg and the rxrb channel interfaces
module rxrb_ctrl
    import rxrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    rxrb_cmd_if.sink            cmd,
    rxrb_rsp_if.source          rsp,
    input  logic [BYTE_W-1:0]   stop_byte,
    input  logic [MINLEN_W-1:0] min_frame_length,
    output ram_req_t            ram_req,
    input  logic [BYTE_W-1:0]   ram_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              flag_reg, flag_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic              out_flag_reg, out_flag_next;
    logic              out_under_reg, out_under_next;

    logic             accept;
    logic             load_out;
    logic             full;
    logic [CNT_W-1:0] rx_count;

    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(RING_DEPTH));
    assign rx_count  = full ? count_reg : count_reg + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        load_out       = 1'b0;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_flag_next  = out_flag_reg;
        out_under_next = out_under_reg;

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = wr_ptr_reg;
        ram_req.wr_data = cmd.rx_byte;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = rd_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_data_next  = '0;
                    out_under_next = 1'b0;
                    unique case (cmd.operation)
                        OP_RECEIVE:
                        begin
                            if (!cmd.rx_error)
                            begin
                                ram_req.wr_en = 1'b1;
                                wr_ptr_next   = wr_ptr_reg + PTR_W'(1);
                                count_next    = rx_count;
                                // full ring: oldest byte is overwritten
                                if (full)
                                begin
                                    rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                                end
                                if ((cmd.rx_byte == stop_byte) &&
                                    (CMP_W'(rx_count) >= CMP_W'(min_frame_length)))
                                begin
                                    flag_next = 1'b1;
                                end
                            end
                            load_out       = 1'b1;
                            out_count_next = count_next;
                            out_flag_next  = flag_next;
                        end
                        OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out       = 1'b1;
                                out_under_next = 1'b1;
                                out_count_next = count_reg;
                                out_flag_next  = flag_reg;
                            end
                            else
                            begin
                                // result follows once the ram data is back
                                ram_req.rd_en = 1'b1;
                                rd_ptr_next   = rd_ptr_reg + PTR_W'(1);
                                count_next    = count_reg - CNT_W'(1);
                                state_next    = ST_READ;
                            end
                        end
                        OP_FLUSH:
                        begin
                            rd_ptr_next    = '0;
                            wr_ptr_next    = '0;
                            count_next     = '0;
                            flag_next      = 1'b0;
                            load_out       = 1'b1;
                            out_count_next = '0;
                            out_flag_next  = 1'b0;
                        end
                        default:
                        begin
                            load_out       = 1'b1;
                            out_count_next = count_reg;
                            out_flag_next  = flag_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load_out       = 1'b1;
                out_data_next  = ram_rd_data;
                out_under_next = 1'b0;
                out_count_next = count_reg;
                out_flag_next  = flag_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_flag_reg  <= out_flag_next;
        out_under_reg <= out_under_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.fill_count  = FILL_W'(out_count_reg);
    assign rsp.frame_ready = out_flag_reg;
    assign rsp.underflow   = out_under_reg;

endmodule

@@ rtl/rx_ring_buffer_with_frame_notify.sv @@
// rx ring buffer with frame notify: receive, read and flush requests on a byte ring
// receive, flush and unused codes give their result the cycle after acceptance;
//   a non-empty read passes the ring store's registered read, then the result register
// throughput: one receive or flush per cycle if rsp.ready; a non-empty read holds the port
// reset: pointers, fill count, notify flag and result valid clear at once, registers to
//   stop byte 0 and minimum frame length 1; the ring store is not cleared, no sweep
// depends on rxrb_pkg, rxrb channel interfaces, rxrb_ctrl and rxrb_ram
module rx_ring_buffer_with_frame_notify
    import rxrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rxrb_cmd_if.sink   cmd,
    rxrb_rsp_if.source rsp,
    rxrb_cfg_if.sink   cfg
);

    // configuration registers; the user writes them only while quiet, not enforced here
    logic [BYTE_W-1:0]   stop_byte_reg, stop_byte_next;
    logic [MINLEN_W-1:0] min_len_reg, min_len_next;

    // ring store request from the sequencer and its registered read data
    ram_req_t          ram_req;
    logic [BYTE_W-1:0] ram_rd_data;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        stop_byte_next = stop_byte_reg;
        min_len_next   = min_len_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_STOP_BYTE: stop_byte_next = cfg.data;
                CFG_MIN_LEN:   min_len_next   = cfg.data[MINLEN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_byte_reg <= '0;
            min_len_reg   <= MINLEN_W'(1);
        end
        else
        begin
            stop_byte_reg <= stop_byte_next;
            min_len_reg   <= min_len_next;
        end
    end

    // pointers, count, notify flag and the result register
    rxrb_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .rsp              (rsp),
        .stop_byte        (stop_byte_reg),
        .min_frame_length (min_len_reg),
        .ram_req          (ram_req),
        .ram_rd_data      (ram_rd_data)
    );

    // the byte ring itself; a write and a read never target the same request
    rxrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef ASSERT_OFF
    // never more bytes reported than the ring holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.fill_count <= FILL_W'(RING_DEPTH)))
        else $error("fill count beyond ring depth");

    // a request is only taken when the result slot is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> (!rsp.valid || rsp.ready))
        else $error("request taken over a pending result");

    // a flush shows an empty ring and a cleared flag in the next cycle
    a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.operation == OP_FLUSH)) |=>
        (rsp.valid && (rsp.fill_count == '0) && !rsp.frame_ready))
        else $error("flush result wrong");

    // an underflow never carries data
    a_underflow_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.underflow) |-> ((rsp.read_data == '0) && (rsp.fill_count == '0)))
        else $error("underflow with data or non-empty ring");
`endif

endmodule
